>>> sv/sspw_pkg.sv
// shared constants, types and the sinc numerator table for the sinc splat weight block
// no dependencies
package sspw_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int TAP_CAP       = 128;
  localparam int POS_FRAC_BITS = 8;
  localparam int FRAC_N        = 1 << POS_FRAC_BITS;

  localparam int DIM_W  = 13;
  localparam int POS_W  = 20;
  localparam int PIX_W  = 12;
  localparam int FLUX_W = 32;
  localparam int INT_W  = POS_W - POS_FRAC_BITS;
  localparam int K_W    = INT_W + 2;
  localparam int D_W    = K_W + POS_FRAC_BITS;
  localparam int T_W    = 29;
  localparam int DVD_W  = T_W + POS_FRAC_BITS;
  localparam int AD_W   = 15;
  localparam int W_W    = 31;
  localparam int TAP_W  = 8;
  localparam int MID_W  = 7;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] PI_Q28  = 64'd843314857;
  localparam logic [W_W-1:0] W_ONE = W_W'(1) << 30;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             inwin;
    logic             fz;
    logic             kz;
    logic             neg;
    logic [AD_W-1:0]  ad;
    logic [DVD_W-1:0] dvd;
  } axis_t;

  typedef struct packed {
    logic              v;
    logic              win;
    logic [FLUX_W-1:0] fm;
    logic              nf;
    logic              fzx;
    logic              kzx;
    logic              negx;
    logic              fzy;
    logic              kzy;
    logic              negy;
  } side_t;

  typedef logic [T_W-1:0] t_tab_t [FRAC_N];

  // sin(pi f)/pi in q30 for one fraction code
  function automatic logic [T_W-1:0] calc_t(input int unsigned fr);
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] p;
    logic [63:0] t;
    g  = (fr <= FRAC_N / 2) ? 64'(fr) : 64'(FRAC_N - fr);
    x  = (PI_Q30 * g) >> POS_FRAC_BITS;
    x2 = (x * x) >> 30;
    h  = Q30_ONE - x2 / 64'd110;
    p  = ((x2 * h) >> 30) / 64'd72;
    h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p  = ((x2 * h) >> 30) / 64'd42;
    h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p  = ((x2 * h) >> 30) / 64'd20;
    h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p  = ((x2 * h) >> 30) / 64'd6;
    h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    h  = (x * h) >> 30;
    if (h > Q30_ONE) h = Q30_ONE;
    t  = (h << 28) / PI_Q28;
    return t[T_W-1:0];
  endfunction

  function automatic t_tab_t build_t_tab();
    t_tab_t tab;
    for (int i = 0; i < FRAC_N; i++) tab[i] = calc_t(i);
    return tab;
  endfunction

  localparam t_tab_t T_TAB = build_t_tab();

endpackage

>>> sv/sinc_source_splat_weight.sv
// top level of the separable truncated sinc splat weight pipeline
// depends on sspw_pkg, sspw_axis, sspw_div, sspw_scale
//
// usage:
//   input beats carry a source flux (q15.16), a source position (q12.8 per axis)
//   and one pixel; each beat yields exactly one output beat with the pixel's
//   addend (q15.16, saturated) and an in-window flag
//   image width and height are set on the cfg port while the block is idle
//   the pipeline is one input register, 37 divider stages (one quotient
//   bit each), two multiplier stages and the saturating output register
//   one beat per cycle is taken unless stalled; every stage holds its own valid bit
//   when the receiver stalls with a beat waiting, the whole pipeline freezes
//   and in_ready drops; nothing is lost or repeated
//   reset clears all valid bits and sets both image sizes to 4096
module sinc_source_splat_weight import sspw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FLUX_W-1:0] in_flux,
  input  logic [POS_W-1:0]  in_source_x,
  input  logic [POS_W-1:0]  in_source_y,
  input  logic [PIX_W-1:0]  in_pixel_col,
  input  logic [PIX_W-1:0]  in_pixel_row,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FLUX_W-1:0] out_addend,
  output logic              out_in_window,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [DIM_W-1:0]  cfg_wdata
);

  logic              en;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  axis_t             axx;
  axis_t             axy;
  axis_t             axx_r;
  axis_t             axy_r;
  side_t             s1_r;
  side_t             s1_nxt;
  side_t             sh_r [DVD_W];
  logic [DVD_W-1:0]  qx;
  logic [DVD_W-1:0]  qy;
  logic              nf;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_DIM);
      height_r <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  sspw_axis u_axis_x (.dim(width_r),  .pos(in_source_x), .pix(in_pixel_col), .ax(axx));
  sspw_axis u_axis_y (.dim(height_r), .pos(in_source_y), .pix(in_pixel_row), .ax(axy));

  always_comb begin
    nf          = in_flux[FLUX_W-1];
    s1_nxt.v    = in_valid;
    s1_nxt.win  = axx.inwin && axy.inwin;
    s1_nxt.fm   = nf ? FLUX_W'(-in_flux) : in_flux;
    s1_nxt.nf   = nf;
    s1_nxt.fzx  = axx.fz;
    s1_nxt.kzx  = axx.kz;
    s1_nxt.negx = axx.neg;
    s1_nxt.fzy  = axy.fz;
    s1_nxt.kzy  = axy.kz;
    s1_nxt.negy = axy.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.v <= 1'b0;
      for (int j = 0; j < DVD_W; j++) sh_r[j].v <= 1'b0;
    end else if (en) begin
      s1_r.v <= s1_nxt.v;
      sh_r[0].v <= s1_r.v;
      for (int j = 1; j < DVD_W; j++) sh_r[j].v <= sh_r[j-1].v;
    end
    if (en) begin
      s1_r.win  <= s1_nxt.win;
      s1_r.fm   <= s1_nxt.fm;
      s1_r.nf   <= s1_nxt.nf;
      s1_r.fzx  <= s1_nxt.fzx;
      s1_r.kzx  <= s1_nxt.kzx;
      s1_r.negx <= s1_nxt.negx;
      s1_r.fzy  <= s1_nxt.fzy;
      s1_r.kzy  <= s1_nxt.kzy;
      s1_r.negy <= s1_nxt.negy;
      axx_r     <= axx;
      axy_r     <= axy;
      sh_r[0].win  <= s1_r.win;
      sh_r[0].fm   <= s1_r.fm;
      sh_r[0].nf   <= s1_r.nf;
      sh_r[0].fzx  <= s1_r.fzx;
      sh_r[0].kzx  <= s1_r.kzx;
      sh_r[0].negx <= s1_r.negx;
      sh_r[0].fzy  <= s1_r.fzy;
      sh_r[0].kzy  <= s1_r.kzy;
      sh_r[0].negy <= s1_r.negy;
      for (int j = 1; j < DVD_W; j++) begin
        sh_r[j].win  <= sh_r[j-1].win;
        sh_r[j].fm   <= sh_r[j-1].fm;
        sh_r[j].nf   <= sh_r[j-1].nf;
        sh_r[j].fzx  <= sh_r[j-1].fzx;
        sh_r[j].kzx  <= sh_r[j-1].kzx;
        sh_r[j].negx <= sh_r[j-1].negx;
        sh_r[j].fzy  <= sh_r[j-1].fzy;
        sh_r[j].kzy  <= sh_r[j-1].kzy;
        sh_r[j].negy <= sh_r[j-1].negy;
      end
    end
  end

  sspw_div u_div_x (.clk(clk), .en(en), .dvd(axx_r.dvd), .dvs(axx_r.ad), .quo(qx));
  sspw_div u_div_y (.clk(clk), .en(en), .dvd(axy_r.dvd), .dvs(axy_r.ad), .quo(qy));

  sspw_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .sd     (sh_r[DVD_W-1]),
    .qx     (qx),
    .qy     (qy),
    .v      (out_valid),
    .addend (out_addend),
    .win    (out_in_window)
  );

endmodule

>>> sv/sspw_axis.sv
// per-axis front end: window test, signed offset, divisor and sinc numerator lookup
// depends on sspw_pkg
module sspw_axis import sspw_pkg::*; (
  input  logic [DIM_W-1:0] dim,
  input  logic [POS_W-1:0] pos,
  input  logic [PIX_W-1:0] pix,
  output axis_t            ax
);

  logic [DIM_W-1:0]        dim_s;
  logic                    in_img;
  logic [TAP_W-1:0]        taps;
  logic [MID_W-1:0]        mid;
  logic [MID_W-1:0]        hi;
  logic signed [K_W-1:0]   k;
  logic [POS_FRAC_BITS-1:0] frac;
  logic signed [D_W-1:0]   d;
  logic [D_W-1:0]          dabs;
  logic                    dneg;

  always_comb begin
    dim_s  = (dim > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim;
    in_img = {1'b0, pix} < dim_s;
    taps   = (dim_s < DIM_W'(TAP_CAP)) ? TAP_W'(dim_s) + TAP_W'(1) : TAP_W'(TAP_CAP + 1);
    mid    = taps[TAP_W-1:1];
    hi     = MID_W'(taps - TAP_W'(1) - {1'b0, mid});
    k      = $signed({2'b00, pix}) - $signed({2'b00, pos[POS_W-1:POS_FRAC_BITS]});
    frac   = pos[POS_FRAC_BITS-1:0];
    d      = $signed({k, {POS_FRAC_BITS{1'b0}}}) - $signed({{K_W{1'b0}}, frac});
    dneg   = d[D_W-1];
    dabs   = dneg ? D_W'(-d) : D_W'(d);

    ax.inwin = in_img && (k >= -$signed({{(K_W-MID_W){1'b0}}, mid}))
                      && (k <= $signed({{(K_W-MID_W){1'b0}}, hi}));
    ax.fz    = (frac == '0);
    ax.kz    = (k == '0);
    ax.neg   = (k[0] == 1'b0) != dneg;
    ax.ad    = (frac == '0) ? AD_W'(1) : dabs[AD_W-1:0];
    ax.dvd   = {T_TAB[frac], {POS_FRAC_BITS{1'b0}}};
  end

endmodule

>>> sv/sspw_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on sspw_pkg
module sspw_div import sspw_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dvd,
  input  logic [AD_W-1:0]  dvs,
  output logic [DVD_W-1:0] quo
);

  logic [AD_W-1:0]  r_r   [DVD_W];
  logic [DVD_W-1:0] q_r   [DVD_W];
  logic [AD_W-1:0]  d_r   [DVD_W];
  logic [AD_W-1:0]  r_nxt [DVD_W];
  logic [DVD_W-1:0] q_nxt [DVD_W];
  logic [AD_W-1:0]  d_nxt [DVD_W];

  always_comb begin
    logic [AD_W-1:0]  rin;
    logic [DVD_W-1:0] qin;
    logic [AD_W-1:0]  din;
    logic [AD_W:0]    tt;
    logic [AD_W:0]    df;
    for (int j = 0; j < DVD_W; j++) begin
      if (j == 0) begin
        rin = '0;
        qin = dvd;
        din = dvs;
      end else begin
        rin = r_r[j-1];
        qin = q_r[j-1];
        din = d_r[j-1];
      end
      tt = {rin, qin[DVD_W-1]};
      df = tt - {1'b0, din};
      if (tt >= {1'b0, din}) begin
        r_nxt[j] = df[AD_W-1:0];
        q_nxt[j] = {qin[DVD_W-2:0], 1'b1};
      end else begin
        r_nxt[j] = tt[AD_W-1:0];
        q_nxt[j] = {qin[DVD_W-2:0], 1'b0};
      end
      d_nxt[j] = din;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DVD_W; j++) begin
        r_r[j] <= r_nxt[j];
        q_r[j] <= q_nxt[j];
        d_r[j] <= d_nxt[j];
      end
    end
  end

  assign quo = q_r[DVD_W-1];

endmodule

>>> sv/sspw_scale.sv
// back end: weight capping, flux times both weights, sign and saturation
// depends on sspw_pkg
module sspw_scale import sspw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  side_t             sd,
  input  logic [DVD_W-1:0]  qx,
  input  logic [DVD_W-1:0]  qy,
  output logic              v,
  output logic [FLUX_W-1:0] addend,
  output logic              win
);

  logic [W_W-1:0] wx;
  logic [W_W-1:0] wy;
  logic           nx;
  logic           ny;

  logic           v1_r, v2_r, v3_r;
  logic           w1_r, w2_r, w3_r;
  logic           n1_r, n2_r;
  logic [W_W-1:0] wy1_r;
  logic [62:0]    p1_r;
  logic [62:0]    p2_r;
  logic [FLUX_W-1:0] res_r;
  logic [FLUX_W-1:0] res_nxt;
  logic [FLUX_W-1:0] m;

  always_comb begin
    if (sd.fzx) wx = sd.kzx ? W_ONE : '0;
    else        wx = (qx > DVD_W'(W_ONE)) ? W_ONE : qx[W_W-1:0];
    if (sd.fzy) wy = sd.kzy ? W_ONE : '0;
    else        wy = (qy > DVD_W'(W_ONE)) ? W_ONE : qy[W_W-1:0];
    nx = !sd.fzx && sd.negx;
    ny = !sd.fzy && sd.negy;
  end

  always_comb begin
    m = p2_r[61:30];
    if (!w2_r || m == '0) begin
      res_nxt = '0;
    end else if (n2_r) begin
      res_nxt = (m > 32'h8000_0000) ? 32'h8000_0000 : FLUX_W'(-m);
    end else begin
      res_nxt = (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= sd.v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= 63'(sd.fm) * 63'(wx);
      wy1_r <= wy;
      w1_r  <= sd.win;
      n1_r  <= sd.nf ^ nx ^ ny;
      p2_r  <= 63'(p1_r[61:30]) * 63'(wy1_r);
      w2_r  <= w1_r;
      n2_r  <= n1_r;
      res_r <= res_nxt;
      w3_r  <= w2_r;
    end
  end

  assign v      = v3_r;
  assign addend = res_r;
  assign win    = w3_r;

endmodule

>>> sv/sspw_checker.sv
// port-level checks for the sinc splat weight block, bound to the top level
// depends on sspw_pkg and sinc_source_splat_weight
module sspw_checker import sspw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FLUX_W-1:0] out_addend,
  input logic              out_in_window
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_addend) && $stable(out_in_window))
    else $error("output beat changed under stall");

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_window |-> out_addend == '0)
    else $error("non-zero addend outside window");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sinc_source_splat_weight sspw_checker u_sspw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_addend    (out_addend),
  .out_in_window (out_in_window)
);
